// ===== hdl/gfpl_pkg.sv =====
// ----------------------------------------------------------------------------
// gfpl_pkg
// Shared widths, limits, status codes and controller states of the
// growable free page list.
// ----------------------------------------------------------------------------
package gfpl_pkg;

   localparam int MAX_PAGES  = 1024;
   localparam int GROW_PAGES = 256;

   localparam int PAGE_W  = $clog2(MAX_PAGES);
   localparam int COUNT_W = $clog2(MAX_PAGES + 1);

   // One growth step and the maximum page count, one bit wider than the count.
   localparam logic [COUNT_W:0]   GROW_INC  = (COUNT_W + 1)'(GROW_PAGES);
   localparam logic [COUNT_W:0]   MAX_WIDE  = (COUNT_W + 1)'(MAX_PAGES);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAGES);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROW,
      ST_POP_RD,
      ST_POP_WR
   } state_type;

endpackage

// ===== hdl/gfpl_ram.sv =====
// ----------------------------------------------------------------------------
// gfpl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gfpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/growable_free_page_list.sv =====
// ----------------------------------------------------------------------------
// growable_free_page_list
// Page allocator whose free pages form a linked list held in a link RAM.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel. req_tuser carries the command (0 to
// allocate, 1 to free) and req_tdata the page to free. Every request gives
// exactly one response on the rsp_ channel with the page handed out, a status
// (ok, store full, invalid page freed) and the page count after the request.
// A free request answers in the cycle after it is taken. An allocate request
// from a non-empty list first reads the head page's link, then in ST_POP_WR
// writes it back cleared and registers the response. When the list is
// empty, the store first grows: one RAM write per new page, for up to
// GROW_PAGES new pages, then the pop runs through ST_POP_RD and ST_POP_WR.
// The single write port of the link RAM makes each new page its own write.
// The block takes a new request once it is idle and its response register is
// empty or being emptied in the same cycle, so a stalled receiver holds
// exactly one finished response and then back-pressures the request side.
// Reset empties the list and sets the page count to zero; the link RAM needs
// no clearing, since an entry is only read after it has been written.
// ----------------------------------------------------------------------------
module growable_free_page_list
   import gfpl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] page_number, upper bits zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [9:0] allocated_page, [11:10] status, [22:12] pages_in_store, [23] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   state_type          state_ff, state_in;
   logic [PAGE_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PAGE_W-1:0]  cursor_ff, cursor_in;
   logic [PAGE_W-1:0]  last_ff, last_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]  rsp_page_ff, rsp_page_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               ram_wr_en;
   logic [PAGE_W-1:0]  ram_wr_addr;
   logic [PAGE_W-1:0]  ram_wr_data;
   logic [PAGE_W-1:0]  ram_rd_data;

   logic               req_accept;
   cmd_type            req_cmd;
   logic [PAGE_W-1:0]  req_page;
   logic               free_bad;
   logic [COUNT_W-1:0] grow_start;
   logic [COUNT_W:0]   grow_sum;
   logic [COUNT_W-1:0] grow_count;
   logic               can_grow;
   logic               cursor_at_last;

   // The link RAM is always read at the head, so the head's link is ready
   // in the cycle after an allocate request is taken.
   gfpl_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (MAX_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign req_cmd    = cmd_type'(req_tuser[0]);
   assign req_page   = req_tdata[PAGE_W-1:0];

   // Page 0 is reserved, and pages at or above the count do not exist yet.
   assign free_bad = (req_page == '0) || ({1'b0, req_page} >= count_ff);

   // Growth starts at the old count, or at page 1 for an empty store, and is
   // capped at the maximum store size.
   assign grow_start = (count_ff <= COUNT_W'(1)) ? COUNT_W'(1) : count_ff;
   assign grow_sum   = {1'b0, count_ff} + GROW_INC;
   assign grow_count = (grow_sum > MAX_WIDE) ? MAX_COUNT : grow_sum[COUNT_W-1:0];
   assign can_grow   = grow_count > grow_start;

   assign cursor_at_last = (cursor_ff == last_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_cmd == CMD_ALLOC)) begin
               if (head_ff != '0) begin
                  state_in = ST_POP_WR;
               end else if (can_grow) begin
                  state_in = ST_GROW;
               end
            end
         end
         ST_GROW: begin
            if (cursor_at_last) begin
               state_in = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_WR;
         end
         ST_POP_WR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM control and response loading.
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      last_in       = last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = head_ff;
      ram_wr_data   = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_FREE) begin
                  // Push the page onto the head unless the page is invalid.
                  rsp_valid_in  = 1'b1;
                  rsp_page_in   = '0;
                  rsp_count_in  = count_ff;
                  if (free_bad) begin
                     rsp_status_in = STATUS_INVALID;
                  end else begin
                     rsp_status_in = STATUS_OK;
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = req_page;
                     ram_wr_data   = head_ff;
                     head_in       = req_page;
                  end
               end else if (head_ff == '0) begin
                  if (can_grow) begin
                     head_in   = grow_start[PAGE_W-1:0];
                     count_in  = grow_count;
                     cursor_in = grow_start[PAGE_W-1:0];
                     last_in   = PAGE_W'(grow_count - COUNT_W'(1));
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_page_in   = '0;
                     rsp_status_in = STATUS_FULL;
                     rsp_count_in  = count_ff;
                  end
               end
            end
         end
         ST_GROW: begin
            // Link each new page to the next; the last one ends the list,
            // which was empty before growth.
            ram_wr_en   = 1'b1;
            ram_wr_addr = cursor_ff;
            ram_wr_data = cursor_at_last ? '0 : cursor_ff + PAGE_W'(1);
            cursor_in   = cursor_ff + PAGE_W'(1);
         end
         ST_POP_RD: begin
            // The head's link is being read.
         end
         ST_POP_WR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = head_ff;
            ram_wr_data   = '0;
            head_in       = ram_rd_data;
            rsp_valid_in  = 1'b1;
            rsp_page_in   = head_ff;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cursor_ff     <= cursor_in;
      last_ff       <= last_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_status_ff, rsp_page_ff};

   // While a request is in progress no earlier response is still waiting.
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a request is in progress");

   // The head is either the empty marker or a page inside the store.
   a_head_in_store: assert property (@(posedge clock) disable iff (reset)
      (head_ff != '0) |-> ({1'b0, head_ff} < count_ff))
      else $error("free list head outside the store");

   // A full answer only comes from a store at its maximum size.
   a_full_at_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL)) |->
      ((rsp_page_ff == '0) && (rsp_count_ff == MAX_COUNT)))
      else $error("full status below the maximum store size");

   // The growth sweep never runs past the last new page.
   a_grow_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW) |-> ((cursor_ff <= last_ff) && ({1'b0, last_ff} < count_ff)))
      else $error("growth cursor past the last new page");

endmodule
